### rtl/core/stp_pkg.sv
// Shared types and constants for the spectrum peak finder.
// Pulled in by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package stp_pkg;

	// Default sizes handed to the top level parameters
	localparam int DEPTH_DEF       = 1024;
	localparam int PEAK_COUNT_DEF  = 4;
	localparam int SAMPLE_BITS_DEF = 24;

	// Half window register
	localparam int          HW_W     = 4;
	localparam int          HW_MAX   = 15;
	localparam logic [3:0]  HW_RESET = 4'd9;

	// Sliding window: center plus HW_MAX taps on each side
	localparam int WIN_TAPS = 2 * HW_MAX + 1;
	localparam int TAP_W    = $clog2(WIN_TAPS);

	// Fixed widths of the result fields
	localparam int POS_OUT_W  = 10;
	localparam int RANK_OUT_W = 2;

	// Control bits that travel with one scan read
	typedef struct packed {
		logic valid;      // a read was issued for this slot
		logic pad_zero;   // index is past the end, feed zero
		logic center_ok;  // the center channel may be a peak
	} scan_ctl_t;

endpackage
`default_nettype wire

### rtl/core/spectrum_top_peak_finder_core.sv
// Top level of the spectrum peak finder: load, scan and result sequencer.
// Depends on stp_pkg, stp_sample_ram, stp_peak_window and stp_rank_list.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+------------------------------------------
//  sample   | start, busy           | sample_value, last_sample
//  result   | result_valid (strobe) | peak_rank, peak_value, peak_position,
//           |                       | peak_found, last_result
//  config   | cfg_wr_en             | cfg_wr_data (half window)
//
// A sample beat without last_sample is stored while fewer than DEPTH are held
// and busy stays low. A beat with last_sample raises busy: the store is read
// once per cycle over indices 0 to count + hw - 1 (hw = half window, 0 treated
// as 1), the read/window/rank pipeline drains, the result register loads, then
// PEAK_COUNT results follow as one unbroken burst. busy drops as the last
// result is shown. The single read port of the store sets the scan length.
// Reset clears control and the rank list; the store needs no clearing since
// only channels below the fill count are read.
// The receiver cannot stall; results are never held.
`timescale 1ns / 1ps
`default_nettype none
module spectrum_top_peak_finder_core #(
	parameter int DEPTH       = stp_pkg::DEPTH_DEF,
	parameter int PEAK_COUNT  = stp_pkg::PEAK_COUNT_DEF,
	parameter int SAMPLE_BITS = stp_pkg::SAMPLE_BITS_DEF
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               start,
	output logic                              busy,
	input  wire [SAMPLE_BITS-1:0]             sample_value,
	input  wire                               last_sample,
	input  wire                               cfg_wr_en,
	input  wire [stp_pkg::HW_W-1:0]           cfg_wr_data,
	output logic                              result_valid,
	output logic [stp_pkg::RANK_OUT_W-1:0]    peak_rank,
	output logic [SAMPLE_BITS-1:0]            peak_value,
	output logic [stp_pkg::POS_OUT_W-1:0]     peak_position,
	output logic                              peak_found,
	output logic                              last_result
);
	import stp_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = $clog2(DEPTH + HW_MAX + 1);
	localparam int RW = (PEAK_COUNT > 1) ? $clog2(PEAK_COUNT) : 1;

	localparam logic [1:0] ST_LOAD  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_EMIT  = 2'd3;

	logic [1:0]             state_q;
	logic [HW_W-1:0]        hw_q;
	logic [HW_W-1:0]        hw_eff;
	logic [CW-1:0]          count_q;
	logic [SW-1:0]          scan_idx_q;
	logic [SW-1:0]          scan_end;
	logic [SW-1:0]          pos_full;
	logic [RW-1:0]          emit_idx_q;
	logic                   accept;
	logic                   store_wr;
	logic [SAMPLE_BITS-1:0] rd_data;
	scan_ctl_t              ctl_s0;
	scan_ctl_t              ctl_s1;
	logic [AW-1:0]          pos_s1;
	logic                   win_active;
	logic                   cand_valid;
	logic [SAMPLE_BITS-1:0] cand_value;
	logic [AW-1:0]          cand_pos;
	logic [PEAK_COUNT-1:0][SAMPLE_BITS-1:0] list_val;
	logic [PEAK_COUNT-1:0][AW-1:0]          list_pos;
	logic [PEAK_COUNT-1:0]                  list_fnd;
	logic [AW+POS_OUT_W-1:0]  pos_ext;
	logic [RW+RANK_OUT_W-1:0] rank_ext;
	logic                   res_valid_q;
	logic [RANK_OUT_W-1:0]  res_rank_q;
	logic [SAMPLE_BITS-1:0] res_value_q;
	logic [POS_OUT_W-1:0]   res_pos_q;
	logic                   res_found_q;
	logic                   res_last_q;

	assign busy     = (state_q != ST_LOAD);
	assign accept   = start && !busy;
	assign store_wr = accept && (count_q < CW'(DEPTH));
	assign hw_eff   = (hw_q == '0) ? HW_W'(1) : hw_q;

	// half window register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hw_q <= HW_RESET;
		end else if (cfg_wr_en) begin
			hw_q <= cfg_wr_data;
		end
	end

	stp_sample_ram #(
		.DEPTH      (DEPTH),
		.SAMPLE_BITS(SAMPLE_BITS),
		.AW         (AW)
	) u_ram (
		.clk    (clk),
		.wr_en  (store_wr),
		.wr_addr(count_q[AW-1:0]),
		.wr_data(sample_value),
		.rd_en  (ctl_s0.valid),
		.rd_addr(scan_idx_q[AW-1:0]),
		.rd_data(rd_data)
	);

	// scan slot decode: index past the end reads as zero,
	// center p = idx - hw needs p >= hw + 1
	assign scan_end         = SW'(count_q) + SW'(hw_eff) - SW'(1);
	assign pos_full         = scan_idx_q - SW'(hw_eff);
	assign ctl_s0.valid     = (state_q == ST_SCAN);
	assign ctl_s0.pad_zero  = (scan_idx_q >= SW'(count_q));
	assign ctl_s0.center_ok = (scan_idx_q >= SW'({hw_eff, 1'b1}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= ctl_s0;
		end
	end

	always_ff @(posedge clk) begin
		pos_s1 <= pos_full[AW-1:0];
	end

	stp_peak_window #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.POS_BITS   (AW)
	) u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.hw        (hw_eff),
		.ctl_s1    (ctl_s1),
		.pos_s1    (pos_s1),
		.rd_data   (rd_data),
		.active    (win_active),
		.cand_valid(cand_valid),
		.cand_value(cand_value),
		.cand_pos  (cand_pos)
	);

	stp_rank_list #(
		.PEAK_COUNT (PEAK_COUNT),
		.SAMPLE_BITS(SAMPLE_BITS),
		.POS_BITS   (AW)
	) u_rank (
		.clk       (clk),
		.arst_n    (arst_n),
		.clear     (accept && last_sample),
		.cand_valid(cand_valid),
		.cand_value(cand_value),
		.cand_pos  (cand_pos),
		.values    (list_val),
		.positions (list_pos),
		.found     (list_fnd)
	);

	// sequencer: load, scan, drain, emit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_LOAD;
			count_q    <= '0;
			scan_idx_q <= '0;
			emit_idx_q <= '0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (store_wr) begin
						count_q <= count_q + CW'(1);
					end
					if (accept && last_sample) begin
						state_q    <= ST_SCAN;
						scan_idx_q <= '0;
					end
				end
				ST_SCAN: begin
					scan_idx_q <= scan_idx_q + SW'(1);
					if (scan_idx_q == scan_end) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!ctl_s1.valid && !win_active) begin
						state_q    <= ST_EMIT;
						emit_idx_q <= '0;
					end
				end
				ST_EMIT: begin
					emit_idx_q <= emit_idx_q + RW'(1);
					if (emit_idx_q == RW'(PEAK_COUNT - 1)) begin
						state_q <= ST_LOAD;
						count_q <= '0;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	// result beat registers
	assign pos_ext  = {{POS_OUT_W{1'b0}}, list_pos[emit_idx_q]};
	assign rank_ext = {{RANK_OUT_W{1'b0}}, emit_idx_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= (state_q == ST_EMIT);
		end
	end

	always_ff @(posedge clk) begin
		res_rank_q  <= rank_ext[RANK_OUT_W-1:0];
		res_value_q <= list_val[emit_idx_q];
		res_pos_q   <= pos_ext[POS_OUT_W-1:0];
		res_found_q <= list_fnd[emit_idx_q];
		res_last_q  <= (emit_idx_q == RW'(PEAK_COUNT - 1));
	end

	assign result_valid  = res_valid_q;
	assign peak_rank     = res_rank_q;
	assign peak_value    = res_value_q;
	assign peak_position = res_pos_q;
	assign peak_found    = res_found_q;
	assign last_result   = res_last_q;

endmodule
`default_nettype wire

### rtl/core/stp_sample_ram.sv
// Sample store: one write port, one read port, registered read data.
// Depends on stp_pkg for default sizes and the house import convention.
`timescale 1ns / 1ps
`default_nettype none
module stp_sample_ram #(
	parameter int DEPTH       = stp_pkg::DEPTH_DEF,
	parameter int SAMPLE_BITS = stp_pkg::SAMPLE_BITS_DEF,
	parameter int AW          = $clog2(stp_pkg::DEPTH_DEF)
) (
	input  wire                   clk,
	input  wire                   wr_en,
	input  wire [AW-1:0]          wr_addr,
	input  wire [SAMPLE_BITS-1:0] wr_data,
	input  wire                   rd_en,
	input  wire [AW-1:0]          rd_addr,
	output logic [SAMPLE_BITS-1:0] rd_data
);
	import stp_pkg::*;

	logic [SAMPLE_BITS-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read port, registered read data
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

### rtl/core/stp_peak_window.sv
// Sliding window over the scanned spectrum and the local maximum test.
// Depends on stp_pkg (scan_ctl_t, window constants).
`timescale 1ns / 1ps
`default_nettype none
module stp_peak_window #(
	parameter int SAMPLE_BITS = stp_pkg::SAMPLE_BITS_DEF,
	parameter int POS_BITS    = $clog2(stp_pkg::DEPTH_DEF)
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire [stp_pkg::HW_W-1:0]   hw,
	input  var  stp_pkg::scan_ctl_t   ctl_s1,
	input  wire [POS_BITS-1:0]        pos_s1,
	input  wire [SAMPLE_BITS-1:0]     rd_data,
	output logic                      active,
	output logic                      cand_valid,
	output logic [SAMPLE_BITS-1:0]    cand_value,
	output logic [POS_BITS-1:0]       cand_pos
);
	import stp_pkg::*;

	logic [WIN_TAPS-1:0][SAMPLE_BITS-1:0] win_q;
	scan_ctl_t                            ctl_s2;
	logic [POS_BITS-1:0]                  pos_s2;
	logic                                 act_s3;
	logic                                 qual_s3;
	logic [SAMPLE_BITS-1:0]               value_s3;
	logic [POS_BITS-1:0]                  pos_s3;
	logic [SAMPLE_BITS-1:0]               center;
	logic [TAP_W-1:0]                     ctr_tap;
	logic [TAP_W-1:0]                     far_tap;
	logic                                 qual;

	// shift line, newest sample at tap 0; past the end shifts in zero
	always_ff @(posedge clk) begin
		if (ctl_s1.valid) begin
			win_q <= {win_q[WIN_TAPS-2:0],
				(ctl_s1.pad_zero ? {SAMPLE_BITS{1'b0}} : rd_data)};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else begin
			ctl_s2 <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		pos_s2 <= pos_s1;
	end

	// center sits hw taps back; it must beat every tap up to 2*hw
	assign ctr_tap = TAP_W'(hw);
	assign far_tap = {hw, 1'b0};
	assign center  = win_q[ctr_tap];

	always_comb begin
		qual = ctl_s2.center_ok;
		for (int j = 0; j < WIN_TAPS; j++) begin
			if ((TAP_W'(j) != ctr_tap) && (TAP_W'(j) <= far_tap) &&
			    !(center > win_q[j])) begin
				qual = 1'b0;
			end
		end
	end

	// candidate register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_s3  <= 1'b0;
			qual_s3 <= 1'b0;
		end else begin
			act_s3  <= ctl_s2.valid;
			qual_s3 <= ctl_s2.valid && qual;
		end
	end

	always_ff @(posedge clk) begin
		value_s3 <= center;
		pos_s3   <= pos_s2;
	end

	assign active     = ctl_s2.valid || act_s3;
	assign cand_valid = qual_s3;
	assign cand_value = value_s3;
	assign cand_pos   = pos_s3;

endmodule
`default_nettype wire

### rtl/core/stp_rank_list.sv
// Sorted list of the largest distinct peak values with first positions.
// Depends on stp_pkg for default sizes.
`timescale 1ns / 1ps
`default_nettype none
module stp_rank_list #(
	parameter int PEAK_COUNT  = stp_pkg::PEAK_COUNT_DEF,
	parameter int SAMPLE_BITS = stp_pkg::SAMPLE_BITS_DEF,
	parameter int POS_BITS    = $clog2(stp_pkg::DEPTH_DEF)
) (
	input  wire                                    clk,
	input  wire                                    arst_n,
	input  wire                                    clear,
	input  wire                                    cand_valid,
	input  wire [SAMPLE_BITS-1:0]                  cand_value,
	input  wire [POS_BITS-1:0]                     cand_pos,
	output logic [PEAK_COUNT-1:0][SAMPLE_BITS-1:0] values,
	output logic [PEAK_COUNT-1:0][POS_BITS-1:0]    positions,
	output logic [PEAK_COUNT-1:0]                  found
);
	import stp_pkg::*;

	logic [PEAK_COUNT-1:0][SAMPLE_BITS-1:0] values_q;
	logic [PEAK_COUNT-1:0][POS_BITS-1:0]    pos_q;
	logic [PEAK_COUNT-1:0]                  found_q;
	logic [PEAK_COUNT-1:0][SAMPLE_BITS-1:0] sh_val;
	logic [PEAK_COUNT-1:0][POS_BITS-1:0]    sh_pos;
	logic [PEAK_COUNT-1:0]                  sh_fnd;
	logic [PEAK_COUNT-1:0]                  gt;
	logic [PEAK_COUNT-1:0]                  eq;
	logic [PEAK_COUNT-1:0]                  gt_prev;
	logic                                   ins;

	// compare the candidate with every entry; gt is a prefix of the list
	always_comb begin
		for (int i = 0; i < PEAK_COUNT; i++) begin
			gt[i] = found_q[i] && (values_q[i] > cand_value);
			eq[i] = found_q[i] && (values_q[i] == cand_value);
		end
	end

	assign gt_prev = (gt << 1) | PEAK_COUNT'(1);
	// equal value already held at a lower position: keep the first one
	assign ins     = cand_valid && !(|eq);

	// entries moved down by one slot
	always_comb begin
		sh_val[0] = cand_value;
		sh_pos[0] = cand_pos;
		sh_fnd[0] = 1'b1;
		for (int i = 1; i < PEAK_COUNT; i++) begin
			sh_val[i] = values_q[i-1];
			sh_pos[i] = pos_q[i-1];
			sh_fnd[i] = found_q[i-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			values_q <= '0;
			pos_q    <= '0;
			found_q  <= '0;
		end else if (clear) begin
			values_q <= '0;
			pos_q    <= '0;
			found_q  <= '0;
		end else if (ins) begin
			for (int i = 0; i < PEAK_COUNT; i++) begin
				if (!gt[i]) begin
					if (gt_prev[i]) begin
						values_q[i] <= cand_value;
						pos_q[i]    <= cand_pos;
						found_q[i]  <= 1'b1;
					end else begin
						values_q[i] <= sh_val[i];
						pos_q[i]    <= sh_pos[i];
						found_q[i]  <= sh_fnd[i];
					end
				end
			end
		end
	end

	assign values    = values_q;
	assign positions = pos_q;
	assign found     = found_q;

endmodule
`default_nettype wire

### rtl/core/stp_checker.sv
// Port-level checks for the spectrum peak finder, bound to the top level.
// Depends on stp_pkg and spectrum_top_peak_finder_core.
`timescale 1ns / 1ps
`default_nettype none
module stp_checker #(
	parameter int SAMPLE_BITS = stp_pkg::SAMPLE_BITS_DEF
) (
	input wire                             clk,
	input wire                             arst_n,
	input wire                             start,
	input wire                             busy,
	input wire                             last_sample,
	input wire                             result_valid,
	input wire [SAMPLE_BITS-1:0]           peak_value,
	input wire [stp_pkg::POS_OUT_W-1:0]    peak_position,
	input wire                             peak_found,
	input wire                             last_result
);
	import stp_pkg::*;

	// a last sample beat starts the ranking
	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && last_sample |=> busy)
		else $error("busy not raised after last sample beat");

	// results come as one unbroken burst
	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last_result |=> result_valid)
		else $error("result burst broken");

	a_burst_end: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && last_result |=> !result_valid)
		else $error("result beat after final result");

	// a missing rank reports zeros
	a_not_found: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !peak_found |-> (peak_value == '0) && (peak_position == '0))
		else $error("nonzero payload on rank not found");

	// found ranks strictly descend and need the rank above
	a_descend: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last_result |=>
			!peak_found || ($past(peak_found) && (peak_value < $past(peak_value))))
		else $error("ranking order violated");

endmodule

bind spectrum_top_peak_finder_core stp_checker #(
	.SAMPLE_BITS(SAMPLE_BITS)
) u_stp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.last_sample  (last_sample),
	.result_valid (result_valid),
	.peak_value   (peak_value),
	.peak_position(peak_position),
	.peak_found   (peak_found),
	.last_result  (last_result)
);
`default_nettype wire
